[design/midi_cc_key_status_table_core_macros.svh]
// ----------------------------------------------------------------------------
// midi_cc_key_status_table_core_macros.svh
// Assertion macros for the key status table checker.
// ----------------------------------------------------------------------------
`ifndef MIDI_CC_KEY_STATUS_TABLE_CORE_MACROS_SVH
`define MIDI_CC_KEY_STATUS_TABLE_CORE_MACROS_SVH

// same-cycle implication, off during reset
`define KST_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, off during reset
`define KST_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// next-cycle implication, live through reset
`define KST_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/kst_pkg.sv]
// ----------------------------------------------------------------------------
// kst_pkg
// Types, codes and helpers for the MIDI CC key status table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package kst_pkg;

   localparam int CSR_IDX_W = 4;

   localparam logic [CSR_IDX_W-1:0] REG_OFF_BRIGHTNESS = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ON_BRIGHTNESS  = 4'd1;

   localparam logic [7:0] OFF_BRIGHTNESS_RST = 8'd13;
   localparam logic [7:0] ON_BRIGHTNESS_RST  = 8'd255;

   localparam logic [4:0] CH_STATUS = 5'd2;
   localparam logic [4:0] CH_PAGE   = 5'd3;

   localparam logic [6:0] CC_PAGE_SELECT = 7'd1;
   localparam logic [6:0] CC_STATUS_FIRST = 7'd1;
   localparam logic [6:0] CC_COLOUR_FIRST = 7'd17;
   localparam logic [6:0] CC_COLOUR_LAST  = 7'd64;

   localparam logic [6:0] STATUS_POP_OFF = 7'd65;
   localparam logic [6:0] STATUS_POP_ON  = 7'd127;

   localparam logic [1:0] COMP_RED   = 2'd0;
   localparam logic [1:0] COMP_GREEN = 2'd1;
   localparam logic [1:0] COMP_BLUE  = 2'd2;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_UPDATE,
      ST_SCAN_READ,
      ST_SCAN_SEND
   } kst_state_type;

   typedef struct packed {
      logic       populated;
      logic       lit;
      logic [6:0] red;
      logic [6:0] green;
      logic [6:0] blue;
   } kst_entry_type;

   typedef struct packed {
      logic [3:0] key_index;
      logic [6:0] red;
      logic [6:0] green;
      logic [6:0] blue;
      logic [7:0] brightness;
      logic       refresh_strip;
      logic       last;
   } kst_led_type;

   // sequencer to entry unit
   typedef struct packed {
      logic       clear;
      logic       rd_en;
      logic       wr_en;
      logic       use_update;
      logic       is_status;
      logic [1:0] comp;
      logic [6:0] value;
      logic [6:0] page;
      logic [3:0] key;
      logic       load_out;
      logic       refresh;
      logic       last;
   } kst_ctl_type;

   // offset / 3 for offsets below 64: multiply by 43/128
   function automatic logic [4:0] kst_div3(input logic [5:0] off);
      logic [11:0] prod;
      prod = {6'd0, off} * 12'd43;
      return prod[11:7];
   endfunction

   function automatic logic [1:0] kst_mod3(input logic [5:0] off, input logic [4:0] quo);
      logic [6:0] three_q;
      logic [6:0] diff;
      three_q = {2'd0, quo} + {1'b0, quo, 1'b0};
      diff    = {1'b0, off} - three_q;
      return diff[1:0];
   endfunction

endpackage

[design/kst_if.sv]
// ----------------------------------------------------------------------------
// kst_if
// Valid/ready channels: MIDI message in, LED command out, register writes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface kst_req_if;
   logic       valid;
   logic       ready;
   logic       is_control_change;
   logic [4:0] channel;
   logic [6:0] controller;
   logic [6:0] value;

   modport source (output valid, is_control_change, channel, controller, value,
                   input ready);
   modport sink   (input valid, is_control_change, channel, controller, value,
                   output ready);
endinterface

interface kst_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] key_index;
   logic [6:0] red;
   logic [6:0] green;
   logic [6:0] blue;
   logic [7:0] brightness;
   logic       refresh_strip;
   logic       last;

   modport source (output valid, key_index, red, green, blue, brightness,
                   refresh_strip, last, input ready);
   modport sink   (input valid, key_index, red, green, blue, brightness,
                   refresh_strip, last, output ready);
endinterface

interface kst_csr_if;
   logic                          valid;
   logic                          ready;
   logic [kst_pkg::CSR_IDX_W-1:0] index;
   logic [7:0]                    data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[design/kst_table.sv]
// ----------------------------------------------------------------------------
// kst_table
// Single-port key table, registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kst_table #(
   parameter int DEPTH  = 2032,
   parameter int ADDR_W = 11
) (
   input  logic                  clock,
   input  logic                  rd_en,
   input  logic                  wr_en,
   input  logic [ADDR_W-1:0]     addr,
   input  kst_pkg::kst_entry_type wr_data,
   output kst_pkg::kst_entry_type rd_data
);

   kst_pkg::kst_entry_type mem [DEPTH];
   kst_pkg::kst_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/kst_entry_unit.sv]
// ----------------------------------------------------------------------------
// kst_entry_unit
// Shared entry datapath: address, read-modify-write, LED formatting.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kst_entry_unit #(
   parameter int KEYS   = 16,
   parameter int DEPTH  = 2032,
   parameter int ADDR_W = 11
) (
   input  logic                 clock,
   input  kst_pkg::kst_ctl_type ctl,
   input  logic [ADDR_W-1:0]    clr_addr,
   input  logic [7:0]           off_brightness,
   input  logic [7:0]           on_brightness,
   output kst_pkg::kst_led_type led
);

   localparam logic [11:0] KEYS_MUL = 12'(KEYS);

   logic [11:0]            lin_addr;
   logic [ADDR_W-1:0]      addr;
   kst_pkg::kst_entry_type rd_data;
   kst_pkg::kst_entry_type upd;
   kst_pkg::kst_entry_type wr_data;
   kst_pkg::kst_entry_type src;

   // page * KEYS + key
   assign lin_addr = ({5'd0, ctl.page} * KEYS_MUL) + {8'd0, ctl.key};
   assign addr     = ctl.clear ? clr_addr : lin_addr[ADDR_W-1:0];

   always_comb begin
      upd = rd_data;
      if (ctl.is_status) begin
         upd.populated = (ctl.value == kst_pkg::STATUS_POP_OFF) ||
                         (ctl.value == kst_pkg::STATUS_POP_ON);
         upd.lit       = (ctl.value == kst_pkg::STATUS_POP_ON);
      end else begin
         case (ctl.comp)
            kst_pkg::COMP_RED:   upd.red   = ctl.value;
            kst_pkg::COMP_GREEN: upd.green = ctl.value;
            kst_pkg::COMP_BLUE:  upd.blue  = ctl.value;
            default:             upd       = rd_data;
         endcase
      end
   end

   assign wr_data = ctl.clear ? '0 : upd;
   assign src     = ctl.use_update ? upd : rd_data;

   always_comb begin
      led.key_index     = ctl.key;
      led.refresh_strip = ctl.refresh;
      led.last          = ctl.last;
      if (src.populated) begin
         led.red        = src.red;
         led.green      = src.green;
         led.blue       = src.blue;
         led.brightness = src.lit ? on_brightness : off_brightness;
      end else begin
         led.red        = '0;
         led.green      = '0;
         led.blue       = '0;
         led.brightness = '0;
      end
   end

   kst_table #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_table (
      .clock   (clock),
      .rd_en   (ctl.rd_en),
      .wr_en   (ctl.wr_en),
      .addr    (addr),
      .wr_data (wr_data),
      .rd_data (rd_data)
   );

endmodule

[design/kst_seq.sv]
// ----------------------------------------------------------------------------
// kst_seq
// Message decode, clearing pass and per-key sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kst_seq #(
   parameter int PAGES  = 127,
   parameter int KEYS   = 16,
   parameter int DEPTH  = 2032,
   parameter int ADDR_W = 11
) (
   input  logic                 clock,
   input  logic                 reset,
   kst_req_if.sink              req,
   input  logic                 out_free,
   output kst_pkg::kst_ctl_type ctl,
   output logic [ADDR_W-1:0]    clr_addr
);

   localparam logic [6:0]        KEYS_CC   = 7'(KEYS);
   localparam logic [4:0]        KEYS_CMP  = 5'(KEYS);
   localparam logic [3:0]        KEY_LAST  = 4'(KEYS - 1);
   localparam logic [6:0]        PAGES_MAX = 7'(PAGES);
   localparam logic [ADDR_W-1:0] CLR_LAST  = ADDR_W'(DEPTH - 1);

   kst_pkg::kst_state_type state_ff, state_in;
   logic [ADDR_W-1:0]      clr_cnt_ff, clr_cnt_in;
   logic [6:0]             page_ff, page_in;
   logic [3:0]             key_ff, key_in;
   logic                   is_status_ff, is_status_in;
   logic [1:0]             comp_ff, comp_in;
   logic [6:0]             value_ff, value_in;

   logic       accept;
   logic       is_cc;
   logic       status_hit;
   logic       colour_hit;
   logic       page_hit;
   logic [6:0] colour_off;
   logic [4:0] colour_key;
   logic [1:0] colour_comp;
   logic [6:0] status_key;
   logic [6:0] page_clamp;
   logic [6:0] new_page;

   // decode
   assign accept      = req.valid && req.ready;
   assign is_cc       = req.is_control_change;
   assign colour_off  = req.controller - kst_pkg::CC_COLOUR_FIRST;
   assign colour_key  = kst_pkg::kst_div3(colour_off[5:0]);
   assign colour_comp = kst_pkg::kst_mod3(colour_off[5:0], colour_key);
   assign status_key  = req.controller - kst_pkg::CC_STATUS_FIRST;

   assign status_hit = is_cc && (req.channel == kst_pkg::CH_STATUS) &&
                       (req.controller >= kst_pkg::CC_STATUS_FIRST) &&
                       (req.controller <= KEYS_CC);
   assign colour_hit = is_cc && (req.channel == kst_pkg::CH_STATUS) &&
                       (req.controller >= kst_pkg::CC_COLOUR_FIRST) &&
                       (req.controller <= kst_pkg::CC_COLOUR_LAST) &&
                       (colour_key < KEYS_CMP);

   always_comb begin
      if (req.value < 7'd1) begin
         page_clamp = 7'd1;
      end else if (req.value > PAGES_MAX) begin
         page_clamp = PAGES_MAX;
      end else begin
         page_clamp = req.value;
      end
   end

   assign new_page = page_clamp - 7'd1;
   assign page_hit = is_cc && (req.channel == kst_pkg::CH_PAGE) &&
                     (req.controller == kst_pkg::CC_PAGE_SELECT) &&
                     (new_page != page_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         kst_pkg::ST_CLEAR: begin
            if (clr_cnt_ff == CLR_LAST) state_in = kst_pkg::ST_IDLE;
         end
         kst_pkg::ST_IDLE: begin
            if (accept && (status_hit || colour_hit)) begin
               state_in = kst_pkg::ST_READ;
            end else if (accept && page_hit) begin
               state_in = kst_pkg::ST_SCAN_READ;
            end
         end
         kst_pkg::ST_READ: state_in = kst_pkg::ST_UPDATE;
         kst_pkg::ST_UPDATE: begin
            if (out_free) state_in = kst_pkg::ST_IDLE;
         end
         kst_pkg::ST_SCAN_READ: state_in = kst_pkg::ST_SCAN_SEND;
         kst_pkg::ST_SCAN_SEND: begin
            if (out_free) begin
               state_in = (key_ff == KEY_LAST) ? kst_pkg::ST_IDLE : kst_pkg::ST_SCAN_READ;
            end
         end
         default: state_in = kst_pkg::ST_CLEAR;
      endcase
   end

   // held message fields and counters
   always_comb begin
      clr_cnt_in   = clr_cnt_ff;
      page_in      = page_ff;
      key_in       = key_ff;
      is_status_in = is_status_ff;
      comp_in      = comp_ff;
      value_in     = value_ff;
      if (state_ff == kst_pkg::ST_CLEAR) begin
         clr_cnt_in = clr_cnt_ff + 1'b1;
      end
      if (state_ff == kst_pkg::ST_IDLE && accept) begin
         value_in = req.value;
         if (status_hit) begin
            is_status_in = 1'b1;
            key_in       = status_key[3:0];
         end else if (colour_hit) begin
            is_status_in = 1'b0;
            key_in       = colour_key[3:0];
            comp_in      = colour_comp;
         end else if (page_hit) begin
            page_in = new_page;
            key_in  = '0;
         end
      end
      if (state_ff == kst_pkg::ST_SCAN_SEND && out_free) begin
         key_in = key_ff + 1'b1;
      end
   end

   // outputs
   always_comb begin
      req.ready      = 1'b0;
      ctl            = '0;
      ctl.is_status  = is_status_ff;
      ctl.comp       = comp_ff;
      ctl.value      = value_ff;
      ctl.page       = page_ff;
      ctl.key        = key_ff;
      unique case (state_ff)
         kst_pkg::ST_CLEAR: begin
            ctl.clear = 1'b1;
            ctl.wr_en = 1'b1;
         end
         kst_pkg::ST_IDLE: req.ready = 1'b1;
         kst_pkg::ST_READ: ctl.rd_en = 1'b1;
         kst_pkg::ST_UPDATE: begin
            ctl.wr_en      = 1'b1;
            ctl.use_update = 1'b1;
            ctl.load_out   = out_free;
            ctl.last       = 1'b1;
         end
         kst_pkg::ST_SCAN_READ: ctl.rd_en = 1'b1;
         kst_pkg::ST_SCAN_SEND: begin
            ctl.load_out = out_free;
            ctl.refresh  = (key_ff == KEY_LAST);
            ctl.last     = (key_ff == KEY_LAST);
         end
         default: ctl = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= kst_pkg::ST_CLEAR;
         clr_cnt_ff <= '0;
         page_ff    <= '0;
      end else begin
         state_ff   <= state_in;
         clr_cnt_ff <= clr_cnt_in;
         page_ff    <= page_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff       <= key_in;
      is_status_ff <= is_status_in;
      comp_ff      <= comp_in;
      value_ff     <= value_in;
   end

   assign clr_addr = clr_cnt_ff;

endmodule

[design/midi_cc_key_status_table_core.sv]
// Status or colour write: READ fetches the entry; UPDATE writes it back and loads the LED word.
// Page change: 16 words, each one table read (SCAN_READ) then one send (SCAN_SEND).
// Input ready only when idle; the single-port key table sets the per-key pace.
// Reset (synchronous) starts a clearing pass over all PAGES*KEYS entries (2032 by
// default), one table entry per cycle; no message is taken until it ends.
// Brightness registers reset to 13 and 255; register writes are always taken.
// ----------------------------------------------------------------------------
// midi_cc_key_status_table_core
// MIDI control-change key status table with per-key LED command output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module midi_cc_key_status_table_core #(
   parameter int PAGES = 127,
   parameter int KEYS  = 16
) (
   input  logic      clock,
   input  logic      reset,
   kst_req_if.sink   req_chan,
   kst_rsp_if.source rsp_chan,
   kst_csr_if.sink   csr_chan
);

   localparam int DEPTH  = PAGES * KEYS;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   kst_pkg::kst_ctl_type ctl;
   kst_pkg::kst_led_type led;
   logic [ADDR_W-1:0]    clr_addr;
   logic                 out_free;

   logic [7:0] off_bright_ff, off_bright_in;
   logic [7:0] on_bright_ff, on_bright_in;

   // output register: one LED word waits here while the sequencer fetches the next
   kst_pkg::kst_led_type rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // ---------------------------------------------------------------- csr
   assign csr_chan.ready = 1'b1;

   always_comb begin
      off_bright_in = off_bright_ff;
      on_bright_in  = on_bright_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.index)
            kst_pkg::REG_OFF_BRIGHTNESS: off_bright_in = csr_chan.data;
            kst_pkg::REG_ON_BRIGHTNESS:  on_bright_in  = csr_chan.data;
            default: begin
               off_bright_in = off_bright_ff;
               on_bright_in  = on_bright_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         off_bright_ff <= kst_pkg::OFF_BRIGHTNESS_RST;
         on_bright_ff  <= kst_pkg::ON_BRIGHTNESS_RST;
      end else begin
         off_bright_ff <= off_bright_in;
         on_bright_ff  <= on_bright_in;
      end
   end

   // ---------------------------------------------------------------- sequencer
   // decodes the message, holds the page, walks keys on a page change
   kst_seq #(
      .PAGES  (PAGES),
      .KEYS   (KEYS),
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_seq (
      .clock    (clock),
      .reset    (reset),
      .req      (req_chan),
      .out_free (out_free),
      .ctl      (ctl),
      .clr_addr (clr_addr)
   );

   // ---------------------------------------------------------------- entry unit
   // one address/update/format path serves every table access
   kst_entry_unit #(
      .KEYS   (KEYS),
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_entry (
      .clock          (clock),
      .ctl            (ctl),
      .clr_addr       (clr_addr),
      .off_brightness (off_bright_ff),
      .on_brightness  (on_bright_ff),
      .led            (led)
   );

   // ---------------------------------------------------------------- output
   // free when empty or when the held word leaves this cycle
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (ctl.load_out) begin
         rsp_in       = led;
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.key_index     = rsp_ff.key_index;
   assign rsp_chan.red           = rsp_ff.red;
   assign rsp_chan.green         = rsp_ff.green;
   assign rsp_chan.blue          = rsp_ff.blue;
   assign rsp_chan.brightness    = rsp_ff.brightness;
   assign rsp_chan.refresh_strip = rsp_ff.refresh_strip;
   assign rsp_chan.last          = rsp_ff.last;

endmodule

[design/kst_checker.sv]
// ----------------------------------------------------------------------------
// kst_checker
// Port-level checks for the key status table, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "midi_cc_key_status_table_core_macros.svh"

module kst_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [3:0] rsp_key_index,
   input logic [6:0] rsp_red,
   input logic [6:0] rsp_green,
   input logic [6:0] rsp_blue,
   input logic [7:0] rsp_brightness,
   input logic       rsp_refresh_strip,
   input logic       rsp_last
);

   logic [32:0] rsp_word;

   assign rsp_word = {rsp_key_index, rsp_red, rsp_green, rsp_blue, rsp_brightness};

   // clearing pass follows reset, so no message is taken right after it
   `KST_ASSERT_NEXT_ALWAYS(a_clear_after_reset, clock, reset, !req_ready, "ready during clear")

   // a page walk in flight keeps the input closed
   `KST_ASSERT_NOW(a_walk_blocks_req, clock, reset, rsp_valid && !rsp_last, !req_ready, "ready mid walk")

   // stalled word holds
   `KST_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_word) && $stable(rsp_refresh_strip) && $stable(rsp_last), "rsp word changed under stall")

endmodule

bind midi_cc_key_status_table_core kst_checker u_kst_checker (
   .clock             (clock),
   .reset             (reset),
   .req_ready         (req_chan.ready),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_key_index     (rsp_chan.key_index),
   .rsp_red           (rsp_chan.red),
   .rsp_green         (rsp_chan.green),
   .rsp_blue          (rsp_chan.blue),
   .rsp_brightness    (rsp_chan.brightness),
   .rsp_refresh_strip (rsp_chan.refresh_strip),
   .rsp_last          (rsp_chan.last)
);

[verif/midi_cc_key_status_table_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_cc_key_status_table_core_tb
// Drives MIDI control-change messages into the key status table and checks
// every LED command word against an in-bench model of the key table, the
// current page and the two brightness registers.
// ----------------------------------------------------------------------------

module midi_cc_key_status_table_core_tb;

   localparam int NUM_PAGES = 127;
   localparam int NUM_KEYS  = 16;

   // Reset starts a clearing pass over all NUM_PAGES*NUM_KEYS entries with no accepts;
   // the long receiver hold-off adds more quiet time. Both fit well inside.
   localparam int WATCHDOG_LIMIT = 6000;
   localparam int HOLD_CYCLES    = 400;
   // Extra wait after the last word lets a message that emits nothing finish.
   localparam int SETTLE_CYCLES  = 40;
   localparam int REPORT_LIMIT   = 10;

   // one MIDI message as the input channel carries it
   typedef struct packed {
      logic       cc;
      logic [4:0] ch;
      logic [6:0] ctl;
      logic [6:0] val;
   } midi_msg_type;

   logic clock;
   logic reset;

   kst_req_if req_if ();
   kst_rsp_if rsp_if ();
   kst_csr_if csr_if ();

   midi_cc_key_status_table_core #(
      .PAGES (NUM_PAGES),
      .KEYS  (NUM_KEYS)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   // ------------------------------------------------------------------------
   // Model state: key table, selected page (page number minus one) and the
   // brightness levels as last written through the register port.
   // ------------------------------------------------------------------------
   kst_pkg::kst_entry_type key_grid [0:NUM_PAGES*NUM_KEYS-1];
   logic [6:0]             page_sel;
   logic [7:0]             off_level;
   logic [7:0]             on_level;

   kst_pkg::kst_led_type led_cmds_due [$];   // LED words still to come, oldest first
   midi_msg_type         msg_queue [$];      // messages not yet offered

   int  send_idle_pct;   // chance (of 100) that the sender skips a cycle
   int  stall_pct;       // chance (of 100) that the receiver stalls a cycle
   bit  rsp_hold;        // long receiver hold-off in progress
   bit  req_taken;       // input word accepted at the last rising edge
   int  n_mismatch;
   int  words_seen;
   int  idle_cycles;

   midi_msg_type         next_msg;
   kst_pkg::kst_led_type seen_word;
   kst_pkg::kst_led_type due_word;

   // LED word for a key of the current page as the table stands now.
   // An empty key shows no colour and no brightness.
   function automatic kst_pkg::kst_led_type led_word(input int key, input bit refresh,
                                                     input bit fin);
      kst_pkg::kst_led_type   w;
      kst_pkg::kst_entry_type e;
      e = key_grid[page_sel * NUM_KEYS + key];
      w.key_index = key[3:0];
      if (e.populated) begin
         w.red        = e.red;
         w.green      = e.green;
         w.blue       = e.blue;
         w.brightness = e.lit ? on_level : off_level;
      end else begin
         w.red        = '0;
         w.green      = '0;
         w.blue       = '0;
         w.brightness = '0;
      end
      w.refresh_strip = refresh;
      w.last          = fin;
      return w;
   endfunction

   // Apply one accepted message to the model and queue the LED words it causes.
   function automatic void apply_midi_msg(input midi_msg_type m);
      int key;
      int offs;
      int pg;
      int slot;
      int k;
      if (!m.cc)
         return;
      if (m.ch == kst_pkg::CH_STATUS) begin
         if (m.ctl >= kst_pkg::CC_STATUS_FIRST && m.ctl <= NUM_KEYS) begin
            // 65 = populated/off, 127 = populated/on, anything else empties
            // the key; its colour stays stored either way
            key  = m.ctl - 1;
            slot = page_sel * NUM_KEYS + key;
            key_grid[slot].populated = (m.val == kst_pkg::STATUS_POP_OFF) ||
                                       (m.val == kst_pkg::STATUS_POP_ON);
            key_grid[slot].lit       = (m.val == kst_pkg::STATUS_POP_ON);
         end else if (m.ctl >= kst_pkg::CC_COLOUR_FIRST &&
                      m.ctl <= kst_pkg::CC_COLOUR_LAST) begin
            // three controllers per key, red first
            offs = m.ctl - kst_pkg::CC_COLOUR_FIRST;
            key  = offs / 3;
            if (key >= NUM_KEYS)
               return;
            slot = page_sel * NUM_KEYS + key;
            case (offs % 3)
               kst_pkg::COMP_RED:   key_grid[slot].red   = m.val;
               kst_pkg::COMP_GREEN: key_grid[slot].green = m.val;
               default:             key_grid[slot].blue  = m.val;
            endcase
         end else begin
            return;
         end
         led_cmds_due.push_back(led_word(key, 1'b0, 1'b1));
      end else if (m.ch == kst_pkg::CH_PAGE && m.ctl == kst_pkg::CC_PAGE_SELECT) begin
         // clamp to 1..NUM_PAGES; same page again emits nothing
         pg = (m.val < 1) ? 1 : int'(m.val);
         if (pg > NUM_PAGES)
            pg = NUM_PAGES;
         pg = pg - 1;
         if (pg == page_sel)
            return;
         page_sel = pg[6:0];
         for (k = 0; k < NUM_KEYS; k++)
            led_cmds_due.push_back(led_word(k, k == NUM_KEYS - 1, k == NUM_KEYS - 1));
      end
   endfunction

   // ------------------------------------------------------------------------
   // Clock
   // ------------------------------------------------------------------------
   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // ------------------------------------------------------------------------
   // Input driver: changes on the falling edge, pulls from msg_queue. A word
   // stays on the channel until taken; a new one may follow right away.
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_taken) begin
         if (msg_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            next_msg = msg_queue.pop_front();
            req_if.valid             <= 1'b1;
            req_if.is_control_change <= next_msg.cc;
            req_if.channel           <= next_msg.ch;
            req_if.controller        <= next_msg.ctl;
            req_if.value             <= next_msg.val;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // Receiver ready: random stalls, or held low during the long hold-off.
   always @(negedge clock) begin
      if (reset || rsp_hold)
         rsp_if.ready <= 1'b0;
      else
         rsp_if.ready <= ($urandom_range(99) >= stall_pct);
   end

   // ------------------------------------------------------------------------
   // Monitor: on the rising edge, predict from accepted messages and check
   // accepted LED words against the oldest expectation.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      req_taken <= req_if.valid && req_if.ready;
      if (!reset && req_if.valid && req_if.ready) begin
         apply_midi_msg('{cc:  req_if.is_control_change, ch:  req_if.channel,
                          ctl: req_if.controller,        val: req_if.value});
      end
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         seen_word.key_index     = rsp_if.key_index;
         seen_word.red           = rsp_if.red;
         seen_word.green         = rsp_if.green;
         seen_word.blue          = rsp_if.blue;
         seen_word.brightness    = rsp_if.brightness;
         seen_word.refresh_strip = rsp_if.refresh_strip;
         seen_word.last          = rsp_if.last;
         words_seen++;
         if (led_cmds_due.size() == 0) begin
            n_mismatch++;
            if (n_mismatch <= REPORT_LIMIT)
               $display("LED word %0d with nothing expected: key %0d", words_seen,
                        seen_word.key_index);
         end else begin
            due_word = led_cmds_due.pop_front();
            if (seen_word.key_index     !== due_word.key_index  ||
                seen_word.red           !== due_word.red        ||
                seen_word.green         !== due_word.green      ||
                seen_word.blue          !== due_word.blue       ||
                seen_word.brightness    !== due_word.brightness ||
                seen_word.refresh_strip !== due_word.refresh_strip ||
                seen_word.last          !== due_word.last) begin
               n_mismatch++;
               if (n_mismatch <= REPORT_LIMIT) begin
                  $display("LED word %0d mismatch at %0t", words_seen, $realtime);
                  $display("  want key %0d rgb %0d/%0d/%0d bri %0d refresh %0b last %0b",
                           due_word.key_index, due_word.red, due_word.green,
                           due_word.blue, due_word.brightness, due_word.refresh_strip,
                           due_word.last);
                  $display("  got  key %0d rgb %0d/%0d/%0d bri %0d refresh %0b last %0b",
                           seen_word.key_index, seen_word.red, seen_word.green,
                           seen_word.blue, seen_word.brightness, seen_word.refresh_strip,
                           seen_word.last);
               end
            end
         end
      end
   end

   // Watchdog: too long without any word moving on any channel.
   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_if.valid && csr_if.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
         $display("Test completed with failures");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   task automatic push_msg(input logic cc, input logic [4:0] ch, input logic [6:0] ctl,
                           input logic [6:0] val);
      msg_queue.push_back('{cc: cc, ch: ch, ctl: ctl, val: val});
   endtask

   // Wait until every queued message is taken and every LED word is back,
   // then give the block time to finish a message that emits nothing.
   task automatic settle();
      while (msg_queue.size() != 0 || req_if.valid || led_cmds_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register write; only called with the block idle.
   task automatic write_reg(input logic [kst_pkg::CSR_IDX_W-1:0] idx,
                            input logic [7:0] data);
      @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= data;
      @(posedge clock);
      while (!csr_if.ready)
         @(posedge clock);
      if (idx == kst_pkg::REG_OFF_BRIGHTNESS)
         off_level = data;
      else
         on_level = data;
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   task automatic set_levels(input logic [7:0] off_val, input logic [7:0] on_val);
      write_reg(kst_pkg::REG_OFF_BRIGHTNESS, off_val);
      write_reg(kst_pkg::REG_ON_BRIGHTNESS, on_val);
   endtask

   // Queue n random messages. Most are status and colour writes and page
   // selects on a handful of low pages, so keys get revisited; the rest is
   // ignored noise.
   task automatic add_random(input int n);
      midi_msg_type m;
      int           pick;
      for (int i = 0; i < n; i++) begin
         pick  = $urandom_range(99);
         m.cc  = 1'b1;
         m.ch  = kst_pkg::CH_STATUS;
         m.ctl = 7'($urandom_range(127));
         m.val = 7'($urandom_range(127));
         if (pick < 30) begin
            m.ctl = 7'($urandom_range(NUM_KEYS, 1));
            case ($urandom_range(3))
               0:       m.val = kst_pkg::STATUS_POP_OFF;
               1:       m.val = kst_pkg::STATUS_POP_ON;
               2:       m.val = '0;
               default: ;   // odd status value empties the key
            endcase
         end else if (pick < 65) begin
            m.ctl = 7'($urandom_range(kst_pkg::CC_COLOUR_LAST, kst_pkg::CC_COLOUR_FIRST));
         end else if (pick < 77) begin
            m.ch  = kst_pkg::CH_PAGE;
            m.ctl = kst_pkg::CC_PAGE_SELECT;
            if ($urandom_range(3) != 0)
               m.val = 7'($urandom_range(4));
         end else begin
            case ($urandom_range(3))
               0: begin
                  m.cc = 1'b0;
                  m.ch = 5'($urandom_range(16, 1));
               end
               1: m.ch = ($urandom_range(1) != 0) ? 5'($urandom_range(16, 4)) : 5'd1;
               2: m.ctl = ($urandom_range(1) != 0) ? 7'($urandom_range(127, 65)) : 7'd0;
               default: begin
                  m.ch  = kst_pkg::CH_PAGE;
                  m.ctl = ($urandom_range(1) != 0) ? 7'($urandom_range(127, 2)) : 7'd0;
               end
            endcase
         end
         msg_queue.push_back(m);
      end
   endtask

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin
      reset                    = 1'b1;
      req_if.valid             = 1'b0;
      req_if.is_control_change = 1'b0;
      req_if.channel           = 5'd1;
      req_if.controller        = '0;
      req_if.value             = '0;
      rsp_if.ready             = 1'b0;
      csr_if.valid             = 1'b0;
      csr_if.index             = '0;
      csr_if.data              = '0;
      send_idle_pct            = 0;
      stall_pct                = 0;
      rsp_hold                 = 1'b0;
      req_taken                = 1'b0;
      n_mismatch               = 0;
      words_seen               = 0;
      idle_cycles              = 0;
      for (int i = 0; i < NUM_PAGES * NUM_KEYS; i++)
         key_grid[i] = '0;
      page_sel  = '0;
      off_level = kst_pkg::OFF_BRIGHTNESS_RST;
      on_level  = kst_pkg::ON_BRIGHTNESS_RST;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // --- directed part, reset brightness levels, no idling ---
      // not a CC, channel 1 and channel 16 are all ignored
      push_msg(1'b0, kst_pkg::CH_STATUS, kst_pkg::CC_STATUS_FIRST, kst_pkg::STATUS_POP_ON);
      push_msg(1'b1, 5'd1, kst_pkg::CC_STATUS_FIRST, kst_pkg::STATUS_POP_ON);
      push_msg(1'b1, 5'd16, 7'd127, 7'd127);
      // key 0 populated and on, then red, green, blue
      push_msg(1'b1, kst_pkg::CH_STATUS, kst_pkg::CC_STATUS_FIRST, kst_pkg::STATUS_POP_ON);
      push_msg(1'b1, kst_pkg::CH_STATUS, kst_pkg::CC_COLOUR_FIRST, 7'd127);
      push_msg(1'b1, kst_pkg::CH_STATUS, 7'd18, 7'd0);
      push_msg(1'b1, kst_pkg::CH_STATUS, 7'd19, 7'd85);
      // key 15 populated and off, then its blue
      push_msg(1'b1, kst_pkg::CH_STATUS, 7'd16, kst_pkg::STATUS_POP_OFF);
      push_msg(1'b1, kst_pkg::CH_STATUS, kst_pkg::CC_COLOUR_LAST, 7'd42);
      push_msg(1'b1, kst_pkg::CH_STATUS, 7'd20, 7'd99);             // colour on an empty key
      push_msg(1'b1, kst_pkg::CH_STATUS, kst_pkg::CC_STATUS_FIRST, 7'd64);   // odd status
      push_msg(1'b1, kst_pkg::CH_STATUS, kst_pkg::CC_STATUS_FIRST, kst_pkg::STATUS_POP_OFF);
      push_msg(1'b1, kst_pkg::CH_STATUS, kst_pkg::CC_STATUS_FIRST, 7'd0);    // empty again
      push_msg(1'b1, kst_pkg::CH_STATUS, 7'd0, 7'd5);               // controller 0: ignored
      push_msg(1'b1, kst_pkg::CH_STATUS, 7'd65, 7'd5);              // past colour range
      push_msg(1'b1, kst_pkg::CH_STATUS, 7'd127, 7'd127);
      push_msg(1'b1, kst_pkg::CH_PAGE, 7'd2, 7'd5);                 // page channel, wrong CC
      push_msg(1'b1, kst_pkg::CH_PAGE, kst_pkg::CC_PAGE_SELECT, 7'd0);     // page 1: same
      push_msg(1'b1, kst_pkg::CH_PAGE, kst_pkg::CC_PAGE_SELECT, 7'd127);   // top page: scan
      push_msg(1'b1, kst_pkg::CH_PAGE, kst_pkg::CC_PAGE_SELECT, 7'd127);   // same: nothing
      push_msg(1'b1, kst_pkg::CH_STATUS, 7'd5, kst_pkg::STATUS_POP_ON);    // key 4, page 127
      push_msg(1'b1, kst_pkg::CH_PAGE, kst_pkg::CC_PAGE_SELECT, 7'd1);     // page 1: scan
      push_msg(1'b1, kst_pkg::CH_STATUS, kst_pkg::CC_STATUS_FIRST, kst_pkg::STATUS_POP_ON);
      settle();

      // --- random, no idling, off level at the bottom ---
      set_levels(8'd0, 8'd255);
      add_random(30);
      settle();

      // --- sender idles; it also pauses midway until all words are back ---
      set_levels(8'd255, 8'd0);
      send_idle_pct = 68;
      stall_pct     = 0;
      add_random(15);
      settle();
      add_random(15);
      settle();

      // --- receiver stalls; a long hold-off at the start backs the block up ---
      set_levels(8'd0, 8'd0);
      send_idle_pct = 0;
      stall_pct     = 68;
      @(posedge clock);
      rsp_hold = 1'b1;
      fork
         begin
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_hold = 1'b0;
         end
      join_none
      push_msg(1'b1, kst_pkg::CH_PAGE, kst_pkg::CC_PAGE_SELECT, 7'd3);
      push_msg(1'b1, kst_pkg::CH_STATUS, 7'd3, kst_pkg::STATUS_POP_ON);
      add_random(30);
      settle();

      // --- both sides idle now and then, both levels at the top ---
      set_levels(8'd255, 8'd255);
      send_idle_pct = 14;
      stall_pct     = 14;
      add_random(30);
      settle();

      // --- random levels, no idling ---
      set_levels(8'($urandom_range(255)), 8'($urandom_range(255)));
      send_idle_pct = 0;
      stall_pct     = 0;
      add_random(20);
      settle();

      if (n_mismatch == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

[sim.f]
+incdir+design
design/kst_pkg.sv
design/kst_if.sv
design/kst_table.sv
design/kst_entry_unit.sv
design/kst_seq.sv
design/midi_cc_key_status_table_core.sv
design/kst_checker.sv
verif/midi_cc_key_status_table_core_tb.sv
